@@ rtl/core/sfa_pkg.sv @@
// Shared types and constants for the surface frame animator.
// Holds the command codes, sequencer states and table row layouts.
// No dependencies.
package sfa_pkg;

    // Default table depths
    localparam int ANIM_ENTRIES_DEF  = 32;
    localparam int FRAME_ENTRIES_DEF = 128;

    // Field widths fixed by the item layout
    localparam int SLOT_W  = 7;
    localparam int COUNT_W = 9;
    localparam int TIC_W   = 8;
    localparam int PIC_W   = 16;

    // Command codes carried on the cmd field
    typedef enum logic [1:0] {
        CMD_LOAD_FRAME = 2'd0,
        CMD_LOAD_ANIM  = 2'd1,
        CMD_TICK       = 2'd2
    } cmd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ANIM,
        ST_RD_FRAME,
        ST_MOD,
        ST_FINISH
    } state_t;

    // Animation table row
    typedef struct packed {
        logic               kind;
        logic [PIC_W-1:0]   surface;
        logic [SLOT_W-1:0]  first;
        logic [SLOT_W-1:0]  last;
        logic [SLOT_W-1:0]  current;
        logic [COUNT_W-1:0] countdown;
    } anim_row_t;

    // Frame table row
    typedef struct packed {
        logic [PIC_W-1:0] picture;
        logic             is_random;
        logic [TIC_W-1:0] hold;
        logic [TIC_W-1:0] range;
    } frame_row_t;

endpackage

@@ rtl/core/surface_frame_animator_top.sv @@
// Surface frame animator: tile animation sequencer around two table memories.
// A load beat lands in its table at the edge that accepts it. A tick runs IDLE
// and RD_ANIM while the countdown stays above zero, adds RD_FRAME and FINISH
// when a hold reloads and MOD before FINISH for a random hold (2-bit-per-cycle
// remainder unit); the result beat is registered, rising as in_ready returns.
// Reset: control and output valid clear asynchronously; table contents are undefined.
module surface_frame_animator_top
    import sfa_pkg::*;
#(
    parameter int ANIM_ENTRIES  = ANIM_ENTRIES_DEF,
    parameter int FRAME_ENTRIES = FRAME_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [4:0]        entry,
    input  logic [SLOT_W-1:0] frame_slot,
    input  logic              kind,
    input  logic [PIC_W-1:0]  surface,
    input  logic [SLOT_W-1:0] first_frame,
    input  logic [SLOT_W-1:0] last_frame,
    input  logic [PIC_W-1:0]  picture,
    input  logic              frame_is_random,
    input  logic [TIC_W-1:0]  hold_tics,
    input  logic [TIC_W-1:0]  tics_range,
    input  logic [TIC_W-1:0]  random_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              surface_kind,
    output logic [PIC_W-1:0]  surface_slot,
    output logic [PIC_W-1:0]  shown_picture
);

    localparam int AIDX_W = (ANIM_ENTRIES > 1) ? $clog2(ANIM_ENTRIES) : 1;
    localparam int FIDX_W = (FRAME_ENTRIES > 1) ? $clog2(FRAME_ENTRIES) : 1;
    localparam int AEXT_W = (AIDX_W > 5) ? AIDX_W : 5;
    localparam int FEXT_W = (FIDX_W > SLOT_W) ? FIDX_W : SLOT_W;

    // Table memories
    anim_row_t  anim_mem  [ANIM_ENTRIES];
    frame_row_t frame_mem [FRAME_ENTRIES];

    // Control and datapath registers
    state_t             state_reg, state_next;
    logic [AIDX_W-1:0]  aidx_reg, aidx_next;
    logic [TIC_W-1:0]   rnd_reg, rnd_next;
    anim_row_t          row_reg, row_next;
    logic               frame_ok_reg, frame_ok_next;
    logic [PIC_W-1:0]   pic_reg, pic_next;
    logic [TIC_W-1:0]   hold_reg, hold_next;
    logic [TIC_W-1:0]   div_reg, div_next;
    logic [TIC_W-1:0]   rem_reg, rem_next;
    logic [TIC_W-1:0]   dvd_reg, dvd_next;
    logic [1:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [PIC_W-1:0]   out_slot_reg, out_slot_next;
    logic [PIC_W-1:0]   out_pic_reg, out_pic_next;

    // Memory port controls
    logic               anim_we;
    logic [AIDX_W-1:0]  anim_waddr;
    anim_row_t          anim_wdata;
    logic [AIDX_W-1:0]  anim_raddr;
    anim_row_t          anim_rd_reg;
    logic               frame_we;
    logic [FIDX_W-1:0]  frame_waddr;
    frame_row_t         frame_wdata;
    logic [FIDX_W-1:0]  frame_raddr;
    frame_row_t         frame_rd_reg;

    // Index and range helpers
    logic [AEXT_W-1:0]  entry_ext;
    logic [FEXT_W-1:0]  fslot_ext;
    logic [FEXT_W-1:0]  next_ext;
    logic               entry_ok;
    logic               fslot_ok;
    logic               in_fire;
    logic               out_free;

    // Step and countdown computation on the freshly read row
    anim_row_t          rd_row;
    logic [COUNT_W-1:0] count_dec;
    logic [SLOT_W:0]    cur_plus;
    logic [SLOT_W-1:0]  next_slot;
    logic               next_ok;
    frame_row_t         frame_eff;
    logic [TIC_W:0]     rem_work;
    logic [TIC_W-1:0]   rem_step;
    logic [TIC_W-1:0]   dvd_step;

    assign entry_ext = AEXT_W'(entry);
    assign fslot_ext = FEXT_W'(frame_slot);
    assign entry_ok  = (32'(entry) < 32'(ANIM_ENTRIES));
    assign fslot_ok  = (32'(frame_slot) < 32'(FRAME_ENTRIES));
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign rd_row    = anim_rd_reg;
    assign count_dec = rd_row.countdown - COUNT_W'(1);
    assign cur_plus  = {1'b0, rd_row.current} + (SLOT_W + 1)'(1);
    assign next_ext  = FEXT_W'(next_slot);
    assign next_ok   = (32'(next_slot) < 32'(FRAME_ENTRIES));
    assign frame_raddr = next_ext[FIDX_W-1:0];

    // Pick the next frame slot: wrap to first at last, else step with table wrap
    always_comb
    begin
        if (rd_row.current == rd_row.last)
        begin
            next_slot = rd_row.first;
        end
        else if (cur_plus[SLOT_W] || (32'(cur_plus) >= 32'(FRAME_ENTRIES)))
        begin
            next_slot = '0;
        end
        else
        begin
            next_slot = cur_plus[SLOT_W-1:0];
        end
    end

    // Treat a slot beyond the frame table as picture 0, fixed hold 0
    assign frame_eff = frame_ok_reg ? frame_rd_reg : '0;

    // Two restoring remainder steps per cycle
    always_comb
    begin
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        rem_work = '0;
        for (int i = 0; i < 2; i++)
        begin
            rem_work = {rem_step, dvd_step[TIC_W-1]};
            dvd_step = {dvd_step[TIC_W-2:0], 1'b0};
            if (rem_work >= {1'b0, div_reg})
            begin
                rem_work = rem_work - {1'b0, div_reg};
            end
            rem_step = rem_work[TIC_W-1:0];
        end
    end

    // Hold the sequencer state, remainder step count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Hold the payload registers
    always_ff @(posedge clk)
    begin
        aidx_reg     <= aidx_next;
        rnd_reg      <= rnd_next;
        row_reg      <= row_next;
        frame_ok_reg <= frame_ok_next;
        pic_reg      <= pic_next;
        hold_reg     <= hold_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_pic_reg  <= out_pic_next;
    end

    // Next state, memory controls and result beat
    always_comb
    begin
        state_next     = state_reg;
        aidx_next      = aidx_reg;
        rnd_next       = rnd_reg;
        row_next       = row_reg;
        frame_ok_next  = frame_ok_reg;
        pic_next       = pic_reg;
        hold_next      = hold_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_pic_next   = out_pic_reg;

        anim_we     = 1'b0;
        anim_waddr  = entry_ext[AIDX_W-1:0];
        anim_wdata  = row_reg;
        anim_raddr  = entry_ext[AIDX_W-1:0];
        frame_we    = 1'b0;
        frame_waddr = fslot_ext[FIDX_W-1:0];
        frame_wdata = '{picture: picture, is_random: frame_is_random,
                        hold: hold_tics, range: tics_range};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        CMD_LOAD_FRAME:
                        begin
                            frame_we = fslot_ok;
                        end
                        CMD_LOAD_ANIM:
                        begin
                            anim_we    = entry_ok;
                            anim_wdata = '{kind: kind, surface: surface,
                                           first: first_frame, last: last_frame,
                                           current: last_frame,
                                           countdown: COUNT_W'(1)};
                        end
                        CMD_TICK:
                        begin
                            if (entry_ok)
                            begin
                                aidx_next  = entry_ext[AIDX_W-1:0];
                                rnd_next   = random_byte;
                                state_next = ST_RD_ANIM;
                            end
                        end
                        default:
                        begin
                            // drop unknown commands
                        end
                    endcase
                end
            end

            ST_RD_ANIM:
            begin
                // Count down; write back at once unless the frame advances
                row_next           = rd_row;
                row_next.countdown = count_dec;
                if (count_dec != '0)
                begin
                    anim_we    = 1'b1;
                    anim_waddr = aidx_reg;
                    anim_wdata = row_next;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next.current = next_slot;
                    frame_ok_next    = next_ok;
                    state_next       = ST_RD_FRAME;
                end
            end

            ST_RD_FRAME:
            begin
                pic_next  = frame_eff.picture;
                hold_next = frame_eff.hold;
                div_next  = frame_eff.range;
                rem_next  = '0;
                dvd_next  = rnd_reg;
                step_next = '0;
                if (frame_eff.is_random && (frame_eff.range != '0))
                begin
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_MOD:
            begin
                rem_next  = rem_step;
                dvd_next  = dvd_step;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Wait for room in the output register, then commit
                if (out_free)
                begin
                    anim_we              = 1'b1;
                    anim_waddr           = aidx_reg;
                    anim_wdata           = row_reg;
                    anim_wdata.countdown = {1'b0, hold_reg} + {1'b0, rem_reg};
                    out_valid_next       = 1'b1;
                    out_kind_next        = row_reg.kind;
                    out_slot_next        = row_reg.surface;
                    out_pic_next         = pic_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Animation table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (anim_we)
        begin
            anim_mem[anim_waddr] <= anim_wdata;
        end
        anim_rd_reg <= anim_mem[anim_raddr];
    end

    // Frame table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign surface_kind  = out_kind_reg;
    assign surface_slot  = out_slot_reg;
    assign shown_picture = out_pic_reg;

endmodule
